@@ src/mes_pkg.sv @@
// Shared types and constants for the motion extremum segmenter.
package mes_pkg;

  localparam int FracBits = 16;
  localparam int AccWidth = 48;

  localparam logic [AccWidth-1:0] AccMax = {1'b0, {(AccWidth-1){1'b1}}};
  localparam logic [AccWidth-1:0] AccMin = {1'b1, {(AccWidth-1){1'b0}}};

  localparam logic [1:0] REG_AXIS    = 2'd0;
  localparam logic [1:0] REG_GRAVITY = 2'd1;

  localparam logic [1:0] EXT_MIN     = 2'd0;
  localparam logic [1:0] EXT_MAX     = 2'd1;
  localparam logic [1:0] EXT_VALLEY  = 2'd2;
  localparam logic [1:0] EXT_PLATEAU = 2'd3;

  localparam logic [1:0] MOVE_PLATEAU = 2'd0;
  localparam logic [1:0] MOVE_UP      = 2'd1;
  localparam logic [1:0] MOVE_DOWN    = 2'd2;

  localparam logic [21:0] GravityReset = 22'd642253;

  typedef struct packed {
    logic        first_of_track;
    logic [31:0] frame_number;
    logic [31:0] sample_time;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
  } sample_t;

  typedef struct packed {
    logic [1:0]  move_kind;
    logic [31:0] from_frame;
    logic [31:0] to_frame;
    logic [31:0] from_time;
    logic [31:0] to_time;
    logic [31:0] shift_x;
    logic [31:0] shift_y;
    logic [31:0] mean_vel_x;
    logic [31:0] mean_vel_y;
    logic [46:0] work_x;
    logic [47:0] work_y;
  } segment_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctrl_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) r = 32'h7fff_ffff;
    else if (v < -64'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [AccWidth-1:0] acc_add(input logic [AccWidth-1:0] acc,
                                                  input logic neg,
                                                  input logic [63:0] m);
    logic signed [65:0] s;
    logic [AccWidth-1:0] r;
    s = neg ? $signed({{18{acc[AccWidth-1]}}, acc}) - $signed({2'b0, m})
            : $signed({{18{acc[AccWidth-1]}}, acc}) + $signed({2'b0, m});
    if (s > $signed({18'b0, AccMax})) r = AccMax;
    else if (s < $signed({{18{1'b1}}, AccMin})) r = AccMin;
    else r = s[AccWidth-1:0];
    return r;
  endfunction

endpackage

@@ src/mes_stream_if.sv @@
// Valid/ready channel interface carrying one payload.
interface mes_stream_if #(
  parameter int W = 1
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/mes_divider.sv @@
// Shared radix-2 restoring divider on magnitudes, one quotient bit a cycle.
module mes_divider import mes_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [63:0] quo_o
);
  logic [63:0] quo_q, quo_d, den_q, den_d;
  logic [64:0] rem_q, rem_d, trial;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;

  always_comb begin
    quo_d = quo_q; den_d = den_q; rem_d = rem_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q[63:0], quo_q[63]} - {1'b0, den_q};
    if (start_i) begin
      quo_d = num_i; den_d = den_i; rem_d = '0; cnt_d = 7'd0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial; quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[63:0], quo_q[63]}; quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; den_q <= den_d; rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

@@ src/mes_multiplier.sv @@
// Shared 32x32 multiplier building 64x64 products from four partial products.
module mes_multiplier import mes_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic         done_o,
  output logic [127:0] prod_o
);
  logic [63:0]  a_q, b_q;
  logic [127:0] acc_q;
  logic [2:0]   step_q;
  logic         busy_q, done_q;
  logic [31:0]  op_a, op_b;
  logic [63:0]  pp;
  logic [127:0] pp_shift;

  always_comb begin
    op_a = step_q[1] ? a_q[63:32] : a_q[31:0];
    op_b = step_q[0] ? b_q[63:32] : b_q[31:0];
    pp = {32'b0, op_a} * {32'b0, op_b};
    pp_shift = {64'b0, pp} << (7'd32 * ({6'b0, step_q[1]} + {6'b0, step_q[0]}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1; step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 3'd1;
        if (step_q == 3'd3) begin
          busy_q <= 1'b0; done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i; b_q <= b_i; acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + pp_shift;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;
endmodule

@@ src/motion_extremum_segmenter_core.sv @@
// Top level: sequencer, track state and result register of the segmenter.
// Sequencing: a sample that opens a track only loads the track state; any other
// sample runs four or six divisions on one shared divider, up to four products
// on one shared multiplier, and sequencer steps. Throughput: input ready only in
// idle; a finished segment waits in the output register, and a following one holds
// before write-back. Reset: async, clears control and track registers, not datapath.
module motion_extremum_segmenter_core import mes_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [21:0] cfg_wdata_i,
  mes_stream_if.sink   in_s,
  mes_stream_if.source out_s
);
  localparam logic [4:0] S_IDLE = 5'd0,  S_DVX = 5'd1,  S_DVY = 5'd2,
                         S_DAX = 5'd3,  S_DAY = 5'd4,  S_EXT = 5'd5,
                         S_MVX = 5'd6,  S_MVY = 5'd7,  S_EMIT = 5'd8,
                         S_ACC = 5'd9,  S_W1 = 5'd10,  S_W2 = 5'd11,
                         S_W3 = 5'd12,  S_W4 = 5'd13,  S_FIN = 5'd14,
                         S_WAITD = 5'd15, S_WAITM = 5'd16;

  logic [4:0]  st_q, ret_q;
  logic        axis_q;
  logic [21:0] grav_q;
  sample_t     smp_q;
  sample_t     in_smp;
  logic        have_sample_q, have_ext_q, emit_q;
  logic [1:0]  last_kind_q, kind_q;
  logic [31:0] prev_frame_q, prev_time_q, prev_px_q, prev_py_q, prev_vx_q, prev_vy_q;
  logic [31:0] vx_q, vy_q, ax_q, ay_q;
  logic [31:0] seg_frame_q, seg_time_q, seg_px_q, seg_py_q, seg_count_q;
  logic [AccWidth-1:0] vsx_q, vsy_q, wsx_q, wsy_q;
  logic [63:0] dtr_q, div_q, tmp_q;
  logic        neg_q;
  segment_t    res_q;
  segment_t    out_q;
  logic        out_v_q;
  logic        out_load;

  logic        d_start, d_busy, d_done, m_start, m_done;
  logic [63:0] d_num, d_den, d_quo, m_a, m_b;
  logic [127:0] m_prod;
  div_ctrl_t   dctl;

  mes_divider u_div (.clk_i, .rst_ni, .start_i(d_start), .num_i(d_num), .den_i(d_den),
                     .busy_o(d_busy), .done_o(d_done), .quo_o(d_quo));
  mes_multiplier u_mul (.clk_i, .rst_ni, .start_i(m_start), .a_i(m_a), .b_i(m_b),
                        .done_o(m_done), .prod_o(m_prod));
  assign dctl = '{start: d_start, busy: d_busy, done: d_done};

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : v;
  endfunction

  function automatic logic signed [63:0] sx(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [63:0] shr_sat(input logic [127:0] p, input int sh);
    logic [127:0] s;
    s = p >> sh;
    return (s[127:64] != '0) ? 64'hffff_ffff_ffff_ffff : s[63:0];
  endfunction

  logic signed [63:0] num_s, lv, rv, sgs, dpy;
  logic [1:0]  kind_c;
  logic        kind_vc;
  logic [63:0] q_signed;
  logic [63:0] cnt64;

  assign in_smp = in_s.data;

  always_comb begin
    num_s = '0;
    case (st_q)
      S_DVX: num_s = sx(smp_q.pos_x) - sx(prev_px_q);
      S_DVY: num_s = sx(smp_q.pos_y) - sx(prev_py_q);
      S_DAX: num_s = sx(vx_q) - sx(prev_vx_q);
      S_DAY: num_s = sx(vy_q) - sx(prev_vy_q);
      default: num_s = '0;
    endcase
    cnt64 = (seg_count_q == '0) ? 64'd1 : {32'b0, seg_count_q};
    d_start = 1'b0; d_num = '0; d_den = mag64(div_q);
    case (st_q)
      S_DVX, S_DVY, S_DAX, S_DAY: begin
        d_start = 1'b1; d_num = mag64(num_s) << FracBits;
      end
      S_MVX: begin
        d_start = have_ext_q; d_num = mag64({{16{vsx_q[AccWidth-1]}}, vsx_q}); d_den = cnt64;
      end
      S_MVY: begin
        d_start = have_ext_q; d_num = mag64({{16{vsy_q[AccWidth-1]}}, vsy_q}); d_den = cnt64;
      end
      default: ;
    endcase
    q_signed = neg_q ? 64'(-d_quo) : d_quo;

    lv = axis_q ? sx(prev_vy_q) : sx(prev_vx_q);
    rv = axis_q ? sx(vy_q) : sx(vx_q);
    kind_vc = 1'b1; kind_c = EXT_MIN;
    if (lv <= 0 && rv > 0) kind_c = EXT_MIN;
    else if (lv >= 0 && rv < 0) kind_c = EXT_MAX;
    else if (lv < 0 && rv == 0) kind_c = EXT_VALLEY;
    else if (lv > 0 && rv == 0) kind_c = EXT_PLATEAU;
    else kind_vc = 1'b0;

    sgs = sx(ay_q) + $signed({42'b0, grav_q});
    dpy = sx(smp_q.pos_y) - sx(prev_py_q);
    m_start = 1'b0; m_a = '0; m_b = '0;
    case (st_q)
      S_W1: begin m_start = 1'b1; m_a = mag64(sx(ax_q)); m_b = mag64(dtr_q); end
      S_W2: begin m_start = 1'b1; m_a = tmp_q; m_b = tmp_q; end
      S_W3: begin
        m_start = 1'b1;
        if (dpy != 0) begin m_a = mag64(dpy); m_b = mag64(sgs); end
        else begin m_a = {42'b0, grav_q}; m_b = mag64(dtr_q); end
      end
      S_W4: begin m_start = 1'b1; m_a = tmp_q; m_b = tmp_q; end
      default: ;
    endcase
  end

  assign out_load = (st_q == S_ACC) && emit_q && (!out_v_q || out_s.ready);

  assign in_s.ready = (st_q == S_IDLE);
  assign out_s.valid = out_v_q;
  assign out_s.data = out_q;

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; ret_q <= S_IDLE; axis_q <= 1'b1; grav_q <= GravityReset;
      have_sample_q <= 1'b0; have_ext_q <= 1'b0; last_kind_q <= EXT_MIN;
      out_v_q <= 1'b0; emit_q <= 1'b0; kind_q <= EXT_MIN;
      prev_frame_q <= '0; prev_time_q <= '0; prev_px_q <= '0; prev_py_q <= '0;
      prev_vx_q <= '0; prev_vy_q <= '0; seg_frame_q <= '0; seg_time_q <= '0;
      seg_px_q <= '0; seg_py_q <= '0; seg_count_q <= '0;
      vsx_q <= '0; vsy_q <= '0; wsx_q <= '0; wsy_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_AXIS) axis_q <= cfg_wdata_i[0];
        else if (cfg_idx_i == REG_GRAVITY) grav_q <= cfg_wdata_i;
      end
      if (out_load) out_v_q <= 1'b1;
      else if (out_v_q && out_s.ready) out_v_q <= 1'b0;
      case (st_q)
        S_IDLE: if (in_s.valid && in_s.ready) begin
          smp_q <= in_smp;
          if (in_smp.first_of_track || !have_sample_q) begin
            have_sample_q <= 1'b1; have_ext_q <= 1'b0; last_kind_q <= EXT_MIN;
            prev_frame_q <= in_smp.frame_number; prev_time_q <= in_smp.sample_time;
            prev_px_q <= in_smp.pos_x; prev_py_q <= in_smp.pos_y;
            prev_vx_q <= '0; prev_vy_q <= '0; seg_frame_q <= '0; seg_time_q <= '0;
            seg_px_q <= '0; seg_py_q <= '0; seg_count_q <= '0;
            vsx_q <= '0; vsy_q <= '0; wsx_q <= '0; wsy_q <= '0;
          end else begin
            dtr_q <= $signed({32'b0, in_smp.sample_time}) - $signed({32'b0, prev_time_q});
            div_q <= (in_smp.sample_time == prev_time_q) ? (64'd1 << FracBits)
                     : $signed({32'b0, in_smp.sample_time}) - $signed({32'b0, prev_time_q});
            st_q <= S_DVX;
          end
        end
        S_DVX, S_DVY, S_DAX, S_DAY, S_MVX, S_MVY: begin
          neg_q <= (st_q == S_MVX) ? vsx_q[AccWidth-1]
                 : (st_q == S_MVY) ? vsy_q[AccWidth-1] : (num_s[63] ^ div_q[63]);
          if (d_start) begin
            ret_q <= st_q; st_q <= S_WAITD;
          end else st_q <= S_EMIT;
        end
        S_WAITD: if (dctl.done) begin
          case (ret_q)
            S_DVX: begin vx_q <= sat32(q_signed); st_q <= S_DVY; end
            S_DVY: begin vy_q <= sat32(q_signed); st_q <= S_DAX; end
            S_DAX: begin ax_q <= sat32(q_signed); st_q <= S_DAY; end
            S_DAY: begin ay_q <= sat32(q_signed); st_q <= S_EXT; end
            S_MVX: begin res_q.mean_vel_x <= sat32(q_signed); st_q <= S_MVY; end
            default: begin res_q.mean_vel_y <= sat32(q_signed); st_q <= S_EMIT; end
          endcase
        end
        S_EXT: begin
          kind_q <= kind_c;
          st_q <= kind_vc ? S_MVX : S_ACC;
        end
        S_EMIT: begin
          if (have_ext_q) begin
            res_q.move_kind <= (last_kind_q == EXT_MAX &&
                                (kind_q == EXT_MIN || kind_q == EXT_VALLEY)) ? MOVE_DOWN :
                               (last_kind_q == EXT_MIN &&
                                (kind_q == EXT_MAX || kind_q == EXT_PLATEAU)) ? MOVE_UP :
                               MOVE_PLATEAU;
            res_q.from_frame <= seg_frame_q; res_q.to_frame <= prev_frame_q;
            res_q.from_time <= seg_time_q; res_q.to_time <= prev_time_q;
            res_q.shift_x <= sat32(sx(prev_px_q) - sx(seg_px_q));
            res_q.shift_y <= sat32(sx(prev_py_q) - sx(seg_py_q));
            res_q.work_x <= wsx_q[AccWidth-1] ? '0 : wsx_q[46:0];
            res_q.work_y <= wsy_q;
            emit_q <= 1'b1;
          end
          have_ext_q <= 1'b1; last_kind_q <= kind_q;
          seg_frame_q <= prev_frame_q; seg_time_q <= prev_time_q;
          seg_px_q <= prev_px_q; seg_py_q <= prev_py_q; seg_count_q <= '0;
          vsx_q <= '0; vsy_q <= '0; wsx_q <= '0; wsy_q <= '0;
          st_q <= S_ACC;
        end
        S_ACC: if (!emit_q || out_load) begin
          emit_q <= 1'b0;
          if (have_ext_q) begin
            vsx_q <= acc_add(vsx_q, prev_vx_q[31], mag64(sx(prev_vx_q)));
            vsy_q <= acc_add(vsy_q, prev_vy_q[31], mag64(sx(prev_vy_q)));
            st_q <= S_W1;
          end else st_q <= S_FIN;
        end
        S_W1, S_W2, S_W3, S_W4: begin ret_q <= st_q; st_q <= S_WAITM; end
        S_WAITM: if (m_done) begin
          case (ret_q)
            S_W1: begin tmp_q <= shr_sat(m_prod, FracBits); st_q <= S_W2; end
            S_W2: begin
              wsx_q <= acc_add(wsx_q, 1'b0, shr_sat(m_prod, FracBits + 1)); st_q <= S_W3;
            end
            S_W3: begin
              if (dpy != 0) begin
                wsy_q <= acc_add(wsy_q, sgs[63], shr_sat(m_prod, FracBits));
                seg_count_q <= (seg_count_q == '1) ? seg_count_q : seg_count_q + 32'd1;
                st_q <= S_FIN;
              end else begin
                tmp_q <= shr_sat(m_prod, FracBits); st_q <= S_W4;
              end
            end
            default: begin
              wsy_q <= acc_add(wsy_q, 1'b0, shr_sat(m_prod, FracBits + 1));
              seg_count_q <= (seg_count_q == '1) ? seg_count_q : seg_count_q + 32'd1;
              st_q <= S_FIN;
            end
          endcase
        end
        S_FIN: begin
          prev_frame_q <= smp_q.frame_number; prev_time_q <= smp_q.sample_time;
          prev_px_q <= smp_q.pos_x; prev_py_q <= smp_q.pos_y;
          prev_vx_q <= vx_q; prev_vy_q <= vy_q; st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_s.valid && in_s.ready && !in_smp.first_of_track && have_sample_q) |=> !in_s.ready)
    else $error("accepted while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_WAITD) |-> (d_busy || d_done)) else $error("divider idle while waited on");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_s.valid && !out_s.ready) |=> (out_s.valid && $stable(out_s.data)))
    else $error("segment dropped or changed while stalled");
endmodule

@@ tb/motion_extremum_segmenter_core_test.sv @@
// Self-checking testbench for the motion extremum segmenter core.
`timescale 1ns / 1ps

module motion_extremum_segmenter_core_test;
  import mes_pkg::*;

  localparam int CycleLimit = 8_000_000;
  localparam int SettleCycles = 600;
  localparam logic [1:0] RegBeyond = 2'd3;
  localparam longint AccTop = (64'sd1 <<< (AccWidth - 1)) - 1;
  localparam longint AccBot = -AccTop - 1;
  localparam longint Q32Max = 64'sd2147483647;
  localparam longint Q32Min = -64'sd2147483648;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [21:0] cfg_wdata_i = '0;

  mes_stream_if #(.W($bits(sample_t)))  smp_if ();
  mes_stream_if #(.W($bits(segment_t))) seg_if ();

  motion_extremum_segmenter_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_s        (smp_if),
    .out_s       (seg_if)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  bit          cfg_axis = 1'b1;
  longint      cfg_grav = GravityReset;
  bit          trk_open;
  bit [31:0]   last_frame, last_time;
  longint      last_px, last_py, last_vx, last_vy;
  bit          ext_seen;
  logic [1:0]  ext_kind;
  bit [31:0]   seg_frame, seg_time, seg_len;
  longint      seg_px, seg_py;
  longint      vsum_x, vsum_y, wsum_x, wsum_y;

  segment_t    seg_expect[$];
  int          mismatches = 0;
  int          segs_checked = 0;
  int          samples_sent = 0;
  int          cycles = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  int          rx_hold = 0;

  initial begin
    smp_if.valid = 1'b0;
    smp_if.data  = '0;
    seg_if.ready = 1'b0;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic bit [63:0] magnitude(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint rate_q(longint num, longint den);
    return clamp((num * 65536) / den, Q32Min, Q32Max);
  endfunction

  function automatic bit [63:0] scaled_product(bit [63:0] a, bit [63:0] b, int sh);
    bit [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    p = p >> sh;
    return (p[127:64] != 0) ? '1 : p[63:0];
  endfunction

  function automatic longint sat_acc(longint acc, bit neg, bit [63:0] m);
    logic signed [129:0] s;
    s = acc;
    if (neg) s = s - $signed({66'b0, m});
    else s = s + $signed({66'b0, m});
    if (s > AccTop) return AccTop;
    if (s < AccBot) return AccBot;
    return longint'(s[63:0]);
  endfunction

  task automatic record_sample(input sample_t s);
    int sx, sy, kind;
    longint px, py, tl, pt, dtr, dv, vx, vy, ax, ay, lv, rv, gs, cnt;
    bit [63:0] ad, term;
    segment_t seg;
    sx = s.pos_x;
    sy = s.pos_y;
    px = sx;
    py = sy;
    if (s.first_of_track || !trk_open) begin
      trk_open = 1'b1;
      last_frame = s.frame_number;
      last_time = s.sample_time;
      last_px = px;
      last_py = py;
      last_vx = 0;
      last_vy = 0;
      ext_seen = 1'b0;
      ext_kind = EXT_MIN;
      seg_frame = 0;
      seg_time = 0;
      seg_px = 0;
      seg_py = 0;
      seg_len = 0;
      vsum_x = 0;
      vsum_y = 0;
      wsum_x = 0;
      wsum_y = 0;
      return;
    end
    tl = s.sample_time;
    pt = last_time;
    dtr = tl - pt;
    dv = (dtr != 0) ? dtr : 65536;
    vx = rate_q(px - last_px, dv);
    vy = rate_q(py - last_py, dv);
    ax = rate_q(vx - last_vx, dv);
    ay = rate_q(vy - last_vy, dv);
    lv = cfg_axis ? last_vy : last_vx;
    rv = cfg_axis ? vy : vx;
    kind = -1;
    if (lv <= 0 && rv > 0) kind = EXT_MIN;
    else if (lv >= 0 && rv < 0) kind = EXT_MAX;
    else if (lv < 0 && rv == 0) kind = EXT_VALLEY;
    else if (lv > 0 && rv == 0) kind = EXT_PLATEAU;

    if (kind >= 0) begin
      if (ext_seen) begin
        cnt = (seg_len != 0) ? longint'(seg_len) : 1;
        seg.move_kind = MOVE_PLATEAU;
        if (ext_kind == EXT_MAX && (kind == EXT_MIN || kind == EXT_VALLEY))
          seg.move_kind = MOVE_DOWN;
        else if (ext_kind == EXT_MIN && (kind == EXT_MAX || kind == EXT_PLATEAU))
          seg.move_kind = MOVE_UP;
        seg.from_frame = seg_frame;
        seg.to_frame   = last_frame;
        seg.from_time  = seg_time;
        seg.to_time    = last_time;
        seg.shift_x    = 32'(clamp(last_px - seg_px, Q32Min, Q32Max));
        seg.shift_y    = 32'(clamp(last_py - seg_py, Q32Min, Q32Max));
        seg.mean_vel_x = 32'(clamp(vsum_x / cnt, Q32Min, Q32Max));
        seg.mean_vel_y = 32'(clamp(vsum_y / cnt, Q32Min, Q32Max));
        seg.work_x     = 47'(clamp(wsum_x, 0, 64'sd140737488355327));
        seg.work_y     = 48'(clamp(wsum_y, -64'sd140737488355328, 64'sd140737488355327));
        seg_expect.insert(seg_expect.size(), seg);
      end
      ext_seen = 1'b1;
      ext_kind = 2'(kind);
      seg_frame = last_frame;
      seg_time = last_time;
      seg_px = last_px;
      seg_py = last_py;
      seg_len = 0;
      vsum_x = 0;
      vsum_y = 0;
      wsum_x = 0;
      wsum_y = 0;
    end

    if (ext_seen) begin
      vsum_x = sat_acc(vsum_x, last_vx < 0, magnitude(last_vx));
      vsum_y = sat_acc(vsum_y, last_vy < 0, magnitude(last_vy));
      ad = scaled_product(magnitude(ax), magnitude(dtr), FracBits);
      term = scaled_product(ad, ad, FracBits + 1);
      wsum_x = sat_acc(wsum_x, 1'b0, term);
      if (py != last_py) begin
        gs = ay + cfg_grav;
        term = scaled_product(magnitude(py - last_py), magnitude(gs), FracBits);
        wsum_y = sat_acc(wsum_y, gs < 0, term);
      end else begin
        ad = scaled_product(cfg_grav, magnitude(dtr), FracBits);
        term = scaled_product(ad, ad, FracBits + 1);
        wsum_y = sat_acc(wsum_y, 1'b0, term);
      end
      if (seg_len != 32'hffff_ffff) seg_len++;
    end

    last_frame = s.frame_number;
    last_time = s.sample_time;
    last_px = px;
    last_py = py;
    last_vx = vx;
    last_vy = vy;
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d segments pending", cycles, seg_expect.size());
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_if.ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      seg_if.ready <= 1'b0;
    end else begin
      seg_if.ready <= !(rx_idle_on && $urandom_range(99) < 22);
    end
  end

  always @(posedge clk_i) begin
    segment_t got, want;
    string bad;
    if (rst_ni && seg_if.valid && seg_if.ready) begin
      got = seg_if.data;
      if (seg_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected segment %p", got);
      end else begin
        want = seg_expect.pop_front();
        segs_checked++;
        bad = "";
        if (got.move_kind   !== want.move_kind)   bad = {bad, " move_kind"};
        if (got.from_frame  !== want.from_frame)  bad = {bad, " from_frame"};
        if (got.to_frame    !== want.to_frame)    bad = {bad, " to_frame"};
        if (got.from_time   !== want.from_time)   bad = {bad, " from_time"};
        if (got.to_time     !== want.to_time)     bad = {bad, " to_time"};
        if (got.shift_x     !== want.shift_x)     bad = {bad, " shift_x"};
        if (got.shift_y     !== want.shift_y)     bad = {bad, " shift_y"};
        if (got.mean_vel_x  !== want.mean_vel_x)  bad = {bad, " mean_vel_x"};
        if (got.mean_vel_y  !== want.mean_vel_y)  bad = {bad, " mean_vel_y"};
        if (got.work_x      !== want.work_x)      bad = {bad, " work_x"};
        if (got.work_y      !== want.work_y)      bad = {bad, " work_y"};
        if (bad != "") begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("segment %0d mismatch in%s", segs_checked, bad);
            $display("  expected %p", want);
            $display("  actual   %p", got);
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [21:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_AXIS) cfg_axis = val[0];
    else if (idx == REG_GRAVITY) cfg_grav = val;
  endtask

  task automatic send_sample(input sample_t s);
    if (tx_idle_on && $urandom_range(99) < 22) begin
      smp_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    smp_if.valid <= 1'b1;
    smp_if.data <= s;
    do @(posedge clk_i); while (!smp_if.ready);
    record_sample(s);
    samples_sent++;
  endtask

  task automatic wait_drained();
    smp_if.valid <= 1'b0;
    while (seg_expect.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic test_directed_cases();
    // no track yet, then min, max, valley, plateau, then saturating jumps
    send_sample('{1'b0, 32'd0, 32'd0, 32'd0, 32'd0});
    send_sample('{1'b0, 32'd1, 32'h0001_0000, 32'd0, 32'h0001_0000});
    send_sample('{1'b0, 32'd2, 32'h0002_0000, 32'h0000_8000, 32'h0003_0000});
    send_sample('{1'b0, 32'd3, 32'h0003_0000, 32'h0000_4000, 32'h0001_0000});
    send_sample('{1'b0, 32'd4, 32'h0003_0000, 32'h0000_4000, 32'h0001_0000});
    send_sample('{1'b0, 32'd5, 32'h0004_0000, 32'hffff_0000, 32'h0002_0000});
    send_sample('{1'b0, 32'd6, 32'h0005_0000, 32'hffff_0000, 32'h0002_0000});
    send_sample('{1'b0, 32'd7, 32'h0002_0000, 32'h0001_0000, 32'hfff0_0000});
    send_sample('{1'b0, 32'd8, 32'h0002_0001, 32'h8000_0000, 32'h7fff_ffff});
    send_sample('{1'b0, 32'd9, 32'h0002_0002, 32'h7fff_ffff, 32'h8000_0000});
    send_sample('{1'b0, 32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff});
    send_sample('{1'b0, 32'h0, 32'h0, 32'h7fff_ffff, 32'h8000_0000});
    send_sample('{1'b0, 32'd12, 32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000});
    send_sample('{1'b0, 32'd13, 32'h0000_0002, 32'h0, 32'h0});
    send_sample('{1'b0, 32'd14, 32'h0000_0003, 32'h0, 32'h0010_0000});
    send_sample('{1'b1, 32'h8000_0000, 32'h8000_0000, 32'h1234_5678, 32'h0});
    send_sample('{1'b0, 32'h8000_0001, 32'h8000_0800, 32'h1234_5678, 32'h0000_0800});
    send_sample('{1'b0, 32'h8000_0002, 32'h8000_1000, 32'h1234_5678, 32'h0000_0400});
    send_sample('{1'b0, 32'h8000_0003, 32'h8000_1800, 32'h1234_5678, 32'h0000_0c00});
    send_sample('{1'b0, 32'h8000_0004, 32'h8000_2000, 32'h1234_5678, 32'h0000_0100});
    wait_drained();
  endtask

  task automatic test_random_tracks(input int n_items);
    int sent, len, r;
    int px, py;
    bit [31:0] frame, tstamp;
    bit up_x, up_y;
    sample_t s;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 5) begin
        s = 129'({$urandom, $urandom, $urandom, $urandom, $urandom});
        send_sample(s);
        sent++;
      end else begin
        len = $urandom_range(3, 40);
        frame = $urandom;
        tstamp = $urandom;
        if ($urandom_range(9) == 0) begin
          px = $urandom;
          py = $urandom;
        end else begin
          px = int'($urandom_range(0, 1 << 24)) - (1 << 23);
          py = int'($urandom_range(0, 1 << 24)) - (1 << 23);
        end
        up_x = $urandom;
        up_y = $urandom;
        for (int k = 0; k < len; k++) begin
          s.first_of_track = (k == 0) && ($urandom_range(9) != 0);
          s.frame_number = frame;
          s.sample_time = tstamp;
          s.pos_x = px;
          s.pos_y = py;
          send_sample(s);
          sent++;
          frame = ($urandom_range(19) == 0) ? $urandom : frame + 1;
          r = $urandom_range(99);
          if (r < 80) tstamp = tstamp + $urandom_range(1000, 3000);
          else if (r < 86) tstamp = tstamp;
          else if (r < 92) tstamp = tstamp - $urandom_range(1, 3000);
          else if (r < 97) tstamp = tstamp + $urandom;
          else tstamp = $urandom;
          if ($urandom_range(99) < 22) up_x = !up_x;
          if ($urandom_range(99) < 22) up_y = !up_y;
          r = $urandom_range(99);
          if (r >= 12) px = up_x ? px + int'($urandom_range(1, r < 95 ? 1 << 17 : 32'h7fff_ffff))
                                 : px - int'($urandom_range(1, r < 95 ? 1 << 17 : 32'h7fff_ffff));
          r = $urandom_range(99);
          if (r >= 12) py = up_y ? py + int'($urandom_range(1, r < 95 ? 1 << 17 : 32'h7fff_ffff))
                                 : py - int'($urandom_range(1, r < 95 ? 1 << 17 : 32'h7fff_ffff));
        end
      end
    end
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    sample_t s;
    rx_hold = 4000;
    for (int k = 0; k < 10; k++) begin
      s.first_of_track = (k == 0);
      s.frame_number = k;
      s.sample_time = k * 2184;
      s.pos_x = k * 4096;
      s.pos_y = (k % 2) ? 32'h0004_0000 : 32'hfffc_0000;
      send_sample(s);
    end
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();

    write_reg(REG_AXIS, 22'h3ffffe);
    write_reg(REG_GRAVITY, 22'd0);
    write_reg(RegBeyond, 22'h3fffff);
    test_random_tracks(320);

    write_reg(REG_AXIS, 22'd1);
    write_reg(REG_GRAVITY, 22'h3fffff);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_tracks(300);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;

    test_output_backpressure();

    write_reg(REG_AXIS, 22'd0);
    write_reg(REG_GRAVITY, 22'($urandom_range(0, 22'h3fffff)));
    test_random_tracks(350);

    write_reg(REG_AXIS, 22'd1);
    write_reg(REG_GRAVITY, GravityReset);
    test_random_tracks(350);

    $display("Ran %0d samples over directed extremes, both axes and gravity corner values,",
             samples_sent);
    $display("output stall and drain phases; %0d segments checked, %0d mismatches.",
             segs_checked, mismatches);
    if (mismatches == 0 && seg_expect.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
